// File: sv/cbac_pkg.sv
// ----------------------------------------------------------------------------
// cbac_pkg: shared types and codes for the contiguous block allocator
// Transaction payloads, action and status codes, controller state encoding
// and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cbac_pkg;

  localparam logic [1:0] ACT_FIRST_FIT = 2'd0;
  localparam logic [1:0] ACT_LARGEST   = 2'd1;
  localparam logic [1:0] ACT_FREE      = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_RUN    = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] size_bytes;
    logic [4:0]  start_block;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  first_block;
    logic [10:0] byte_offset;
    logic [5:0]  blocks_granted;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_CLAIM,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_rd;
    logic finish;
    logic claim_wr;
  } cmd_t;

  typedef struct packed {
    logic last_addr;
    logic claim_req;
    logic claim_last;
  } sts_t;

endpackage

`default_nettype wire

// File: sv/contiguous_block_allocator.sv
// ----------------------------------------------------------------------------
// contiguous_block_allocator: first-fit / largest-run block allocator
// Manages NUM_BLOCKS blocks of BLOCK_BYTES bytes through per-block owner tags.
//
// Usage:
//   in_*  channel: one request transaction (action, size_bytes, start_block).
//         Action first fit tags the lowest free run covering size_bytes,
//         largest tags the longest free run (earliest on ties), free clears
//         every block owned by start_block.
//   out_* channel: exactly one result transaction per request (status,
//         first_block, byte_offset, blocks_granted).
//   Timing: one request at a time. out_valid rises once the scan, drain and
//   decide states that follow acceptance are through, and the claim as well
//   for a successful allocate; the tag scan reads the tag RAM once per block
//   through its single read port, and the claim writes one block per cycle.
//   in_ready is high again the cycle after the result is taken.
//   Reset: all owner tags read as free at once (per-block valid bits are
//   cleared); no clearing pass, the block is ready right after reset.
//   Stall: a result held by a low out_ready stays on out_data unchanged and
//   no new request is taken until it leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module contiguous_block_allocator #(
  parameter int BLOCK_BYTES = 64,
  parameter int NUM_BLOCKS  = 32
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire cbac_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output cbac_pkg::out_t      out_data
);

  // command and status bundles between sequencer and datapath
  cbac_pkg::cmd_t cmd;
  cbac_pkg::sts_t sts;

  // sequencer: accept, scan, decide, claim, hold result
  cbac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: tag store, run tracking and the result register
  cbac_dpath #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .NUM_BLOCKS  (NUM_BLOCKS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// File: sv/cbac_ram.sv
// ----------------------------------------------------------------------------
// cbac_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cbac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/cbac_ctrl.sv
// ----------------------------------------------------------------------------
// cbac_ctrl: allocator sequencer
// Walks each transaction through scan, decision, tag claim and hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module cbac_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire cbac_pkg::sts_t sts,
  output cbac_pkg::cmd_t     cmd
);

  cbac_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cbac_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cbac_pkg::S_IDLE: begin
        if (in_valid) state_nxt = cbac_pkg::S_SCAN;
      end
      cbac_pkg::S_SCAN: begin
        if (sts.last_addr) state_nxt = cbac_pkg::S_DRAIN;
      end
      cbac_pkg::S_DRAIN: begin
        state_nxt = cbac_pkg::S_DECIDE;
      end
      cbac_pkg::S_DECIDE: begin
        state_nxt = sts.claim_req ? cbac_pkg::S_CLAIM : cbac_pkg::S_DONE;
      end
      cbac_pkg::S_CLAIM: begin
        if (sts.claim_last) state_nxt = cbac_pkg::S_DONE;
      end
      cbac_pkg::S_DONE: begin
        if (out_ready) state_nxt = cbac_pkg::S_IDLE;
      end
      default: begin
        state_nxt = cbac_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd          = '0;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    case (state_r)
      cbac_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      cbac_pkg::S_SCAN:   cmd.scan_rd  = 1'b1;
      cbac_pkg::S_DECIDE: cmd.finish   = 1'b1;
      cbac_pkg::S_CLAIM:  cmd.claim_wr = 1'b1;
      cbac_pkg::S_DONE:   out_valid    = 1'b1;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: sv/cbac_dpath.sv
// ----------------------------------------------------------------------------
// cbac_dpath: allocator datapath
// Tag RAM with per-block valid bits, sequential run scan, claim writer and
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cbac_dpath #(
  parameter int BLOCK_BYTES = 64,
  parameter int NUM_BLOCKS  = 32
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire cbac_pkg::in_t  in_data,
  input  wire cbac_pkg::cmd_t cmd,
  output cbac_pkg::sts_t      sts,
  output cbac_pkg::out_t      out_data
);

  localparam int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);
  localparam int TAG_W      = CNT_W;
  localparam int CMP_W      = (TAG_W > 6) ? TAG_W : 6;
  localparam int POOL_BYTES = NUM_BLOCKS * BLOCK_BYTES;
  localparam int PB_W       = $clog2(POOL_BYTES + 1);
  localparam int SZ_W       = (PB_W > 16) ? PB_W : 16;
  localparam int FW         = (IDX_W > 5) ? IDX_W : 5;
  localparam int PW         = FW + 13;

  cbac_pkg::in_t    req_r;
  logic             size_ok_r;
  logic [IDX_W-1:0] rd_addr_r;
  logic             d_vld_r;
  logic [IDX_W-1:0] d_idx_r;
  logic [NUM_BLOCKS-1:0] vld_r, vld_nxt;
  logic [TAG_W-1:0] ram_q;

  logic [IDX_W-1:0] seg_head_r, seg_head_nxt;
  logic [CNT_W-1:0] run_len_r, run_len_nxt;
  logic [SZ_W-1:0]  run_bytes_r, run_bytes_nxt;
  logic [IDX_W-1:0] best_start_r, best_start_nxt;
  logic [CNT_W-1:0] best_len_r, best_len_nxt;
  logic             found_r, found_nxt;
  logic [CNT_W-1:0] free_cnt_r, free_cnt_nxt;
  logic [CNT_W-1:0] wr_off_r;

  logic             is_ff, is_lg, is_fr;
  logic             blk_free, tag_hit;
  logic [IDX_W-1:0] rs;
  logic [CNT_W-1:0] rl;
  logic [SZ_W-1:0]  rb;
  logic [IDX_W-1:0] claim_addr;
  logic [TAG_W-1:0] claim_tag;

  logic [1:0]       res_status;
  logic [FW-1:0]    res_first;
  logic [CNT_W-1:0] res_cnt;
  logic [PW-1:0]    res_prod;
  logic [CMP_W-1:0] res_cnt_ext;
  cbac_pkg::out_t   out_r;

  assign is_ff = (req_r.action == cbac_pkg::ACT_FIRST_FIT);
  assign is_lg = (req_r.action == cbac_pkg::ACT_LARGEST);
  assign is_fr = (req_r.action == cbac_pkg::ACT_FREE);

  assign claim_addr = best_start_r + IDX_W'(wr_off_r);
  assign claim_tag  = TAG_W'(best_start_r) + TAG_W'(1);

  cbac_ram #(
    .WIDTH (TAG_W),
    .DEPTH (NUM_BLOCKS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (cmd.claim_wr),
    .waddr (claim_addr),
    .wdata (claim_tag),
    .raddr (rd_addr_r),
    .rdata (ram_q)
  );

  // a block is free when its valid bit is clear; stale RAM contents never leak
  assign blk_free = !vld_r[d_idx_r];
  assign tag_hit  = vld_r[d_idx_r] &&
                    (CMP_W'(ram_q) == (CMP_W'(req_r.start_block) + CMP_W'(1)));

  assign rs = (run_len_r == '0) ? d_idx_r : seg_head_r;
  assign rl = run_len_r + CNT_W'(1);
  assign rb = run_bytes_r + SZ_W'(BLOCK_BYTES);

  always_comb begin
    seg_head_nxt   = seg_head_r;
    run_len_nxt    = run_len_r;
    run_bytes_nxt  = run_bytes_r;
    best_start_nxt = best_start_r;
    best_len_nxt   = best_len_r;
    found_nxt      = found_r;
    free_cnt_nxt   = free_cnt_r;
    vld_nxt        = vld_r;
    if (cmd.load) begin
      seg_head_nxt   = '0;
      run_len_nxt    = '0;
      run_bytes_nxt  = '0;
      best_start_nxt = '0;
      best_len_nxt   = '0;
      found_nxt      = 1'b0;
      free_cnt_nxt   = '0;
    end else if (d_vld_r) begin
      if (blk_free) begin
        if (!(is_ff && found_r)) begin
          seg_head_nxt  = rs;
          run_len_nxt   = rl;
          run_bytes_nxt = rb;
        end
        if (is_ff && !found_r && size_ok_r && (rb >= SZ_W'(req_r.size_bytes))) begin
          found_nxt      = 1'b1;
          best_start_nxt = rs;
          best_len_nxt   = rl;
        end
        if (is_lg && (rl > best_len_r)) begin
          found_nxt      = 1'b1;
          best_start_nxt = rs;
          best_len_nxt   = rl;
        end
      end else begin
        run_len_nxt   = '0;
        run_bytes_nxt = '0;
      end
      if (is_fr && tag_hit) begin
        vld_nxt[d_idx_r] = 1'b0;
        free_cnt_nxt     = free_cnt_r + CNT_W'(1);
      end
    end
    if (cmd.claim_wr) begin
      vld_nxt[claim_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      d_vld_r  <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      vld_r    <= vld_nxt;
      d_vld_r  <= cmd.scan_rd;
      found_r  <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seg_head_r   <= seg_head_nxt;
    run_len_r    <= run_len_nxt;
    run_bytes_r  <= run_bytes_nxt;
    best_start_r <= best_start_nxt;
    best_len_r   <= best_len_nxt;
    free_cnt_r   <= free_cnt_nxt;
    d_idx_r      <= rd_addr_r;
    if (cmd.load) begin
      req_r     <= in_data;
      size_ok_r <= (in_data.size_bytes != 16'd0) &&
                   (SZ_W'(in_data.size_bytes) <= SZ_W'(POOL_BYTES));
      rd_addr_r <= '0;
    end else if (cmd.scan_rd) begin
      rd_addr_r <= rd_addr_r + IDX_W'(1);
    end
    if (cmd.finish) begin
      wr_off_r <= '0;
    end else if (cmd.claim_wr) begin
      wr_off_r <= wr_off_r + CNT_W'(1);
    end
    if (cmd.finish) begin
      out_r <= {res_status, res_first[4:0], res_prod[10:0], res_cnt_ext[5:0]};
    end
  end

  always_comb begin
    res_status = cbac_pkg::ST_NO_RUN;
    res_first  = '0;
    res_cnt    = '0;
    case (req_r.action)
      cbac_pkg::ACT_FIRST_FIT, cbac_pkg::ACT_LARGEST: begin
        if (found_r) begin
          res_status = cbac_pkg::ST_OK;
          res_first  = FW'(best_start_r);
          res_cnt    = best_len_r;
        end
      end
      cbac_pkg::ACT_FREE: begin
        if (free_cnt_r != '0) begin
          res_status = cbac_pkg::ST_OK;
          res_first  = FW'(req_r.start_block);
          res_cnt    = free_cnt_r;
        end else begin
          res_status = cbac_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        res_status = cbac_pkg::ST_NO_RUN;
      end
    endcase
  end

  assign res_prod    = PW'(res_first) * PW'(BLOCK_BYTES);
  assign res_cnt_ext = CMP_W'(res_cnt);

  assign sts.last_addr  = (rd_addr_r == IDX_W'(NUM_BLOCKS - 1));
  assign sts.claim_req  = found_r && (is_ff || is_lg);
  assign sts.claim_last = ((wr_off_r + CNT_W'(1)) == best_len_r);
  assign out_data       = out_r;

endmodule

`default_nettype wire

// File: tb/cbac_alloc_checker.sv
// ----------------------------------------------------------------------------
// cbac_alloc_checker: scoreboard for the contiguous block allocator
// Mirrors the owner tags of the pool, works out the result of every accepted
// request and compares each returned result with the oldest one outstanding.
// ----------------------------------------------------------------------------
module cbac_alloc_checker #(
  parameter int BLOCK_BYTES = 64,
  parameter int NUM_BLOCKS  = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  cbac_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  cbac_pkg::out_t out_data,
  output int             mismatch_count,
  output int             results_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import cbac_pkg::*;

  // 0 = free, otherwise start block of the owning allocation plus one
  logic [5:0] block_owner [NUM_BLOCKS];
  out_t       expected_results [$];

  initial begin
    mismatch_count  = 0;
    results_pending = 0;
  end

  function automatic out_t predict_allocation(in_t req);
    out_t res;
    int   need, b, seg_head, run_len, best_start, best_len, freed;
    res        = '0;
    res.status = ST_NO_RUN;
    seg_head   = 0;
    run_len    = 0;
    best_start = 0;
    best_len   = 0;
    freed      = 0;
    case (req.action)
      ACT_FIRST_FIT: begin
        need = (int'(req.size_bytes) + BLOCK_BYTES - 1) / BLOCK_BYTES;
        if (need > 0 && need <= NUM_BLOCKS) begin
          for (b = 0; b < NUM_BLOCKS && run_len < need; b++) begin
            if (block_owner[b] == '0) begin
              if (run_len == 0) seg_head = b;
              run_len++;
            end else begin
              run_len = 0;
            end
          end
          if (run_len == need) begin
            best_start = seg_head;
            best_len   = need;
          end
        end
      end
      ACT_LARGEST: begin
        for (b = 0; b < NUM_BLOCKS; b++) begin
          if (block_owner[b] == '0) begin
            if (run_len == 0) seg_head = b;
            run_len++;
            // strictly longer only, so the earliest run wins a tie
            if (run_len > best_len) begin
              best_len   = run_len;
              best_start = seg_head;
            end
          end else begin
            run_len = 0;
          end
        end
      end
      ACT_FREE: begin
        for (b = 0; b < NUM_BLOCKS; b++) begin
          if (block_owner[b] == {1'b0, req.start_block} + 6'd1) begin
            block_owner[b] = '0;
            freed++;
          end
        end
        if (freed == 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          res.status         = ST_OK;
          res.first_block    = req.start_block;
          res.byte_offset    = 11'(int'(req.start_block) * BLOCK_BYTES);
          res.blocks_granted = 6'(freed);
        end
      end
      default: ;
    endcase
    // claim the chosen run for either kind of allocate
    if (best_len > 0) begin
      for (b = best_start; b < best_start + best_len; b++) block_owner[b] = 6'(best_start + 1);
      res.status         = ST_OK;
      res.first_block    = 5'(best_start);
      res.byte_offset    = 11'(best_start * BLOCK_BYTES);
      res.blocks_granted = 6'(best_len);
    end
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input int want, input int got);
    mismatch_count++;
    $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    out_t want;
    int   b;
    if (!rst_n) begin
      for (b = 0; b < NUM_BLOCKS; b++) block_owner[b] = '0;
      expected_results.delete();
      results_pending = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $display("%0t ns: result mismatch: expected none, actual status %0d block %0d",
                   $time, out_data.status, out_data.first_block);
        end else begin
          want = expected_results.pop_front();
          if (out_data.status != want.status)
            flag_mismatch("status", want.status, out_data.status);
          if (out_data.first_block != want.first_block)
            flag_mismatch("first_block", want.first_block, out_data.first_block);
          if (out_data.byte_offset != want.byte_offset)
            flag_mismatch("byte_offset", want.byte_offset, out_data.byte_offset);
          if (out_data.blocks_granted != want.blocks_granted)
            flag_mismatch("blocks_granted", want.blocks_granted, out_data.blocks_granted);
        end
      end
      if (in_valid && in_ready) expected_results.push_back(predict_allocation(in_data));
      results_pending = expected_results.size();
    end
  end

endmodule

// File: tb/tb_contiguous_block_allocator.sv
// ----------------------------------------------------------------------------
// tb_contiguous_block_allocator: top level for the block allocator
// Drives a directed set of corner requests and then a long random mix of
// allocate and free transactions, with bursty sending and a stalling result
// side. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_contiguous_block_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import cbac_pkg::*;

  localparam int BLOCK_BYTES     = 64;
  localparam int NUM_BLOCKS      = 32;
  localparam int CLK_HALF        = 10;
  localparam int RESET_CYCLES    = 6;
  localparam int RANDOM_REQUESTS = 1900;
  localparam int DRAIN_EVERY     = 400;
  // slowest request runs a full scan and then claims every block
  localparam int SETTLE_CYCLES   = 80;
  localparam int CYCLE_LIMIT     = 1_500_000;

  // action code the block does not define; must answer "no run"
  localparam logic [1:0] ACT_RESERVED = 2'd3;

  typedef enum int {RX_OPEN, RX_COIN, RX_BURSTY} rx_mode_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  int         mismatch_count;
  int         results_pending;
  int         burst_left  = 0;
  int         cycle_count = 0;
  rx_mode_t   rx_mode     = RX_OPEN;
  int         stall_left  = 0;
  int         rx_tick     = 0;
  // start blocks currently held, learned from granted results
  int         live_starts [$];
  logic [1:0] inflight_actions [$];

  always #(CLK_HALF) clk = ~clk;

  contiguous_block_allocator #(
    .BLOCK_BYTES(BLOCK_BYTES),
    .NUM_BLOCKS (NUM_BLOCKS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  cbac_alloc_checker #(
    .BLOCK_BYTES(BLOCK_BYTES),
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_alloc_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .results_pending(results_pending)
  );

  // Result side: switch between always ready, coin-toss ready and bursts of
  // stall, so that stalls land on every part of a request.
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 128 == 0) rx_mode <= rx_mode_t'($urandom_range(0, 2));
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN: out_ready <= 1'b1;
        RX_COIN: out_ready <= 1'($urandom_range(0, 1));
        default: begin
          if ($urandom_range(0, 3) == 0) begin
            stall_left <= $urandom_range(1, 12);
            out_ready  <= 1'b0;
          end else begin
            out_ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // Track which starts are held so that most frees hit a live allocation.
  // Sample at the falling edge: a handshake seen here completes at the next
  // rising edge, and nothing here races the stimulus process.
  always @(negedge clk) begin
    logic [1:0] act;
    int         k;
    if (rst_n && in_valid && in_ready) inflight_actions.push_back(in_data.action);
    if (rst_n && out_valid && out_ready && inflight_actions.size() > 0) begin
      act = inflight_actions.pop_front();
      if (out_data.status == ST_OK) begin
        if (act == ACT_FREE) begin
          // drop every stale copy of the freed start
          k = 0;
          while (k < live_starts.size()) begin
            if (live_starts[k] == out_data.first_block) live_starts.delete(k);
            else k++;
          end
        end else begin
          live_starts.push_back(out_data.first_block);
        end
      end
    end
  end

  function automatic in_t make_req(input logic [1:0] act, input logic [15:0] size,
                                   input logic [4:0] start);
    in_t r;
    r.action      = act;
    r.size_bytes  = size;
    r.start_block = start;
    return r;
  endfunction

  // Present one transaction and hold it until taken. Then either carry on
  // within the burst, leave a random gap, or hold off until every result
  // outstanding has come back.
  task automatic send_request(input in_t req, input logic drain_after);
    int gap;
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0 && !drain_after) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      if (drain_after) begin
        while (results_pending != 0) @(negedge clk);
        @(posedge clk);
      end else begin
        // mostly short gaps, sometimes long enough to span a whole scan
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 80) : $urandom_range(1, 8);
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
    end
  endtask

  initial begin
    in_t req;
    int  n, choice, pick;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed corners, pool empty after reset.
    // Zero-size request, request larger than the pool, free of an unknown start
    send_request(make_req(ACT_FIRST_FIT, 16'd0, 5'd0), 1'b0);
    send_request(make_req(ACT_FIRST_FIT, 16'hFFFF, 5'd31), 1'b0);
    send_request(make_req(ACT_FIRST_FIT, 16'd2049, 5'd0), 1'b0);
    send_request(make_req(ACT_FREE, 16'd0, 5'd0), 1'b0);
    // largest takes the whole pool, then nothing is left for anyone
    send_request(make_req(ACT_LARGEST, 16'hFFFF, 5'd31), 1'b0);
    send_request(make_req(ACT_LARGEST, 16'd0, 5'd0), 1'b0);
    send_request(make_req(ACT_FIRST_FIT, 16'd1, 5'd0), 1'b0);
    send_request(make_req(ACT_FREE, 16'hFFFF, 5'd0), 1'b0);
    // exactly the pool size, then free it back
    send_request(make_req(ACT_FIRST_FIT, 16'd2048, 5'd0), 1'b0);
    send_request(make_req(ACT_FREE, 16'd0, 5'd31), 1'b0);
    send_request(make_req(ACT_FREE, 16'd0, 5'd0), 1'b0);
    // rounding up to whole blocks, then first fit into a hole
    send_request(make_req(ACT_FIRST_FIT, 16'd1, 5'd0), 1'b0);
    send_request(make_req(ACT_FIRST_FIT, 16'd64, 5'd0), 1'b0);
    send_request(make_req(ACT_FIRST_FIT, 16'd65, 5'd0), 1'b0);
    send_request(make_req(ACT_FIRST_FIT, 16'd128, 5'd0), 1'b0);
    send_request(make_req(ACT_FREE, 16'd0, 5'd1), 1'b0);
    send_request(make_req(ACT_FIRST_FIT, 16'd130, 5'd0), 1'b0);
    send_request(make_req(ACT_FIRST_FIT, 16'd64, 5'd0), 1'b0);
    send_request(make_req(ACT_LARGEST, 16'd0, 5'd0), 1'b0);
    // unused action code with every payload bit set
    send_request(make_req(ACT_RESERVED, 16'hFFFF, 5'd31), 1'b0);
    send_request(make_req(ACT_FREE, 16'd0, 5'd2), 1'b0);
    send_request(make_req(ACT_FREE, 16'd0, 5'd4), 1'b0);
    // largest picks the hole in the middle, then drain before random traffic
    send_request(make_req(ACT_LARGEST, 16'd0, 5'd0), 1'b1);

    // Random traffic: mostly allocate/free pairs on live starts, with noise.
    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      // fill the ignored fields with junk so every bit toggles
      req.action      = 2'($urandom);
      req.size_bytes  = 16'($urandom);
      req.start_block = 5'($urandom);
      choice = $urandom_range(0, 99);
      if (choice < 45) begin
        req.action = ACT_FIRST_FIT;
        pick = $urandom_range(0, 19);
        if (pick < 16) begin
          req.size_bytes = 16'($urandom_range(1, 512));
        end else if (pick < 18) begin
          req.size_bytes = 16'($urandom_range(513, 2048));
        end else if (pick == 19) begin
          case ($urandom_range(0, 3))
            0:       req.size_bytes = 16'd0;
            1:       req.size_bytes = 16'd2048;
            2:       req.size_bytes = 16'd2049;
            default: req.size_bytes = 16'hFFFF;
          endcase
        end
        // otherwise keep the full-range random size
      end else if (choice < 55) begin
        req.action = ACT_LARGEST;
      end else if (choice < 93) begin
        req.action = ACT_FREE;
        if (live_starts.size() > 0) begin
          pick = $urandom_range(0, live_starts.size() - 1);
          req.start_block = 5'(live_starts[pick]);
          live_starts.delete(pick);
        end
      end else if (choice < 98) begin
        req.action = ACT_FREE;
      end else begin
        req.action = ACT_RESERVED;
      end
      send_request(req, (n % DRAIN_EVERY == DRAIN_EVERY - 1) || (n == RANDOM_REQUESTS - 1));
    end

    // last request drained all results; allow any late stray output to show
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // Watchdog: abandon a hung run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

endmodule
